[rtl/sbrp_pkg.sv]
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared types and constants for the sound board reply parser.
// ----------------------------------------------------------------------------
package sbrp_pkg;

  localparam int DEF_VOICE_SLOTS = 16;
  localparam int DEF_FRAME_MAX   = 32;
  localparam int DEF_TEXT_LEN    = 23;

  localparam int STORE_DEPTH = 32;

  localparam logic [7:0]  START_A     = 8'hF0;
  localparam logic [7:0]  START_B     = 8'hAA;
  localparam logic [7:0]  END_MARK    = 8'h55;
  localparam logic [7:0]  MIN_LEN     = 8'd5;
  localparam logic [7:0]  RSP_VERSION = 8'd129;
  localparam logic [7:0]  RSP_INFO    = 8'd130;
  localparam logic [7:0]  RSP_TRACK   = 8'd132;
  localparam logic [15:0] IDLE_TRACK  = 16'hFFFF;

  typedef enum logic [2:0] {
    FN_RX      = 3'd0,
    FN_PLAYING = 3'd1,
    FN_VOICE   = 3'd2,
    FN_VERSION = 3'd3,
    FN_CLEAR   = 3'd4
  } func_t;

  // one-hot command strobes for the item being processed
  typedef struct packed {
    logic rx;
    logic playing;
    logic voice;
    logic version;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic       done;
    logic [7:0] code;
  } frame_evt_t;

  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

endpackage

[rtl/sound_board_reply_parser_top.sv]
// ----------------------------------------------------------------------------
// sound_board_reply_parser_top
// Receive side of a serial sound player link: reply deframing, voice track
// table, version text and system info, with query items.
//
//   channel | signals                                   | dir
//   in      | in_valid in_ready func rx_byte            | in
//           | track_number voice_index char_index       |
//   out     | out_valid out_ready frame_done reply_code | out
//           | track_playing voice_track version_char    |
//           | version_ready info_ready voice_count      |
//           | track_count                               |
//
// One item per cycle while the result is taken or empty; each item passes the
// input register, then the decode and query logic into the result register.
// Every item gives exactly one result item.
// rst is synchronous and clears all tables; a clear item does the same.
// A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
module sound_board_reply_parser_top #(
  parameter int VOICE_SLOTS = sbrp_pkg::DEF_VOICE_SLOTS,
  parameter int FRAME_MAX   = sbrp_pkg::DEF_FRAME_MAX,
  parameter int TEXT_LEN    = sbrp_pkg::DEF_TEXT_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] track_number,
  input  logic [7:0]  voice_index,
  input  logic [4:0]  char_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_done,
  output logic [7:0]  reply_code,
  output logic        track_playing,
  output logic [15:0] voice_track,
  output logic [7:0]  version_char,
  output logic        version_ready,
  output logic        info_ready,
  output logic [7:0]  voice_count,
  output logic [15:0] track_count
);

  logic        s1_valid;
  logic [2:0]  s1_func;
  logic [7:0]  s1_byte;
  logic [15:0] s1_track;
  logic [7:0]  s1_voice;
  logic [4:0]  s1_char;
  logic        adv;
  logic        fire;

  sbrp_pkg::cmd_t       cmd;
  sbrp_pkg::frame_evt_t evt;
  sbrp_pkg::store_t     store;

  logic        q_playing;
  logic [15:0] q_vtrack;
  logic [7:0]  q_vchar;
  logic        q_vready;
  logic        q_iready;
  logic [7:0]  q_vcount;
  logic [15:0] q_tcount;

  assign adv      = !out_valid || out_ready;
  assign fire     = s1_valid && adv;
  assign in_ready = !s1_valid || adv;

  always_comb begin
    cmd = '0;
    unique case (s1_func)
      sbrp_pkg::FN_RX:      cmd.rx      = 1'b1;
      sbrp_pkg::FN_PLAYING: cmd.playing = 1'b1;
      sbrp_pkg::FN_VOICE:   cmd.voice   = 1'b1;
      sbrp_pkg::FN_VERSION: cmd.version = 1'b1;
      sbrp_pkg::FN_CLEAR:   cmd.clear   = 1'b1;
      default:              cmd         = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func  <= func;
      s1_byte  <= rx_byte;
      s1_track <= track_number;
      s1_voice <= voice_index;
      s1_char  <= char_index;
    end
  end

  sbrp_framer #(
    .FRAME_MAX(FRAME_MAX)
  ) u_framer (
    .clk    (clk),
    .rst    (rst),
    .rx_en  (fire && cmd.rx),
    .clr    (fire && cmd.clear),
    .rx_byte(s1_byte),
    .evt    (evt),
    .store  (store)
  );

  sbrp_tables #(
    .VOICE_SLOTS(VOICE_SLOTS),
    .TEXT_LEN   (TEXT_LEN)
  ) u_tables (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .cmd          (cmd),
    .evt          (evt),
    .store        (store),
    .track_number (s1_track),
    .voice_index  (s1_voice),
    .char_index   (s1_char),
    .track_playing(q_playing),
    .voice_track  (q_vtrack),
    .version_char (q_vchar),
    .version_ready(q_vready),
    .info_ready   (q_iready),
    .voice_count  (q_vcount),
    .track_count  (q_tcount)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      frame_done    <= evt.done;
      reply_code    <= evt.code;
      track_playing <= q_playing;
      voice_track   <= q_vtrack;
      version_char  <= q_vchar;
      version_ready <= q_vready;
      info_ready    <= q_iready;
      voice_count   <= q_vcount;
      track_count   <= q_tcount;
    end
  end

endmodule

[rtl/sbrp_framer.sv]
// ----------------------------------------------------------------------------
// sbrp_framer
// Deframes reply bytes (F0 AA len payload 55) and holds the payload bytes.
// ----------------------------------------------------------------------------
module sbrp_framer #(
  parameter int FRAME_MAX = sbrp_pkg::DEF_FRAME_MAX
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_en,
  input  logic                 clr,
  input  logic [7:0]           rx_byte,
  output sbrp_pkg::frame_evt_t evt,
  output sbrp_pkg::store_t     store
);

  logic [5:0] pos;
  logic [5:0] pos_next;
  logic [5:0] end_pos;
  logic [5:0] end_pos_next;
  logic       wr_en;
  logic [4:0] wr_idx;
  logic       done;

  assign wr_idx = 5'(pos - 6'd3);

  always_comb begin
    pos_next     = pos;
    end_pos_next = end_pos;
    wr_en        = 1'b0;
    done         = 1'b0;
    if (rx_en) begin
      priority if (pos == 6'd0) begin
        // stray end marks and other bytes are ignored while hunting
        if (rx_byte == sbrp_pkg::START_A) pos_next = 6'd1;
      end else if (pos == 6'd1) begin
        pos_next = (rx_byte == sbrp_pkg::START_B) ? 6'd2 : 6'd0;
      end else if (pos == 6'd2) begin
        if (rx_byte >= sbrp_pkg::MIN_LEN && rx_byte <= 8'(FRAME_MAX)) begin
          pos_next     = 6'd3;
          end_pos_next = 6'(rx_byte - 8'd1);
        end else begin
          pos_next = 6'd0;
        end
      end else if (pos < end_pos) begin
        wr_en    = 1'b1;
        pos_next = pos + 6'd1;
      end else if (pos == end_pos) begin
        if (rx_byte == sbrp_pkg::END_MARK) begin
          done         = 1'b1;
          end_pos_next = 6'd0;
        end
        pos_next = 6'd0;
      end else begin
        pos_next = 6'd0;
      end
    end
  end

  assign evt.done = done;
  assign evt.code = done ? store[0] : 8'd0;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      pos     <= 6'd0;
      end_pos <= 6'd0;
      store   <= '0;
    end else begin
      pos     <= pos_next;
      end_pos <= end_pos_next;
      if (wr_en) store[wr_idx] <= rx_byte;
    end
  end

endmodule

[rtl/sbrp_tables.sv]
// ----------------------------------------------------------------------------
// sbrp_tables
// Decodes completed replies into the voice table, version text and counts,
// and answers the query items.
// ----------------------------------------------------------------------------
module sbrp_tables #(
  parameter int VOICE_SLOTS = sbrp_pkg::DEF_VOICE_SLOTS,
  parameter int TEXT_LEN    = sbrp_pkg::DEF_TEXT_LEN
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  sbrp_pkg::cmd_t       cmd,
  input  sbrp_pkg::frame_evt_t evt,
  input  sbrp_pkg::store_t     store,
  input  logic [15:0]          track_number,
  input  logic [7:0]           voice_index,
  input  logic [4:0]           char_index,
  output logic                 track_playing,
  output logic [15:0]          voice_track,
  output logic [7:0]           version_char,
  output logic                 version_ready,
  output logic                 info_ready,
  output logic [7:0]           voice_count,
  output logic [15:0]          track_count
);

  localparam int TEXT_DEPTH = TEXT_LEN - 1;

  logic [15:0] vt         [VOICE_SLOTS];
  logic [15:0] vt_next    [VOICE_SLOTS];
  logic [7:0]  vtext      [TEXT_DEPTH];
  logic [7:0]  vtext_next [TEXT_DEPTH];
  logic        vflag;
  logic        vflag_next;
  logic        iflag;
  logic        iflag_next;
  logic [7:0]  voices;
  logic [7:0]  voices_next;
  logic [15:0] tracks;
  logic [15:0] tracks_next;
  logic        clr;
  logic        upd;
  logic [15:0] rep_track;

  assign clr       = fire && cmd.clear;
  assign upd       = fire && evt.done;
  assign rep_track = {store[2], store[1]} + 16'd1;

  always_comb begin
    vt_next     = vt;
    vtext_next  = vtext;
    vflag_next  = vflag;
    iflag_next  = iflag;
    voices_next = voices;
    tracks_next = tracks;
    if (upd) begin
      if (evt.code == sbrp_pkg::RSP_TRACK) begin
        for (int i = 0; i < VOICE_SLOTS; i++) begin
          if (store[3] == 8'(i)) begin
            if (store[4] != 8'd0) vt_next[i] = rep_track;
            else if (vt[i] == rep_track) vt_next[i] = sbrp_pkg::IDLE_TRACK;
          end
        end
      end else if (evt.code == sbrp_pkg::RSP_VERSION) begin
        for (int i = 0; i < TEXT_DEPTH; i++) vtext_next[i] = store[i+1];
        vflag_next = 1'b1;
      end else if (evt.code == sbrp_pkg::RSP_INFO) begin
        voices_next = store[1];
        tracks_next = {store[3], store[2]};
        iflag_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < VOICE_SLOTS; i++) vt[i] <= sbrp_pkg::IDLE_TRACK;
      for (int i = 0; i < TEXT_DEPTH; i++) vtext[i] <= 8'd0;
      vflag  <= 1'b0;
      iflag  <= 1'b0;
      voices <= 8'd0;
      tracks <= 16'd0;
    end else begin
      vt     <= vt_next;
      vtext  <= vtext_next;
      vflag  <= vflag_next;
      iflag  <= iflag_next;
      voices <= voices_next;
      tracks <= tracks_next;
    end
  end

  // queries see the state before this item; status shows the state after it
  always_comb begin
    track_playing = 1'b0;
    voice_track   = 16'd0;
    version_char  = 8'd0;
    if (cmd.playing) begin
      for (int i = 0; i < VOICE_SLOTS; i++)
        if (vt[i] == track_number) track_playing = 1'b1;
    end
    if (cmd.voice) begin
      voice_track = sbrp_pkg::IDLE_TRACK;
      for (int i = 0; i < VOICE_SLOTS; i++)
        if (voice_index == 8'(i)) voice_track = vt[i];
    end
    if (cmd.version && vflag) begin
      for (int i = 0; i < TEXT_DEPTH; i++)
        if (char_index == 5'(i)) version_char = vtext[i];
    end
  end

  assign version_ready = clr ? 1'b0  : vflag_next;
  assign info_ready    = clr ? 1'b0  : iflag_next;
  assign voice_count   = clr ? 8'd0  : voices_next;
  assign track_count   = clr ? 16'd0 : tracks_next;

endmodule
